@@ src/nearest_waypoint_search_top_defines.svh @@
// Assertion macros for the nearest waypoint search block.
// Used by nearest_waypoint_search_top.sv; depends on clk and arst_n in scope.
`ifndef NEAREST_WAYPOINT_SEARCH_TOP_DEFINES_SVH
`define NEAREST_WAYPOINT_SEARCH_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NWS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("nearest_waypoint_search: check failed");
`define NWS_ASSERT_IMP(lbl, pre, post) \
	`NWS_ASSERT(lbl, (pre) |-> (post))
`else
`define NWS_ASSERT(lbl, prop)
`define NWS_ASSERT_IMP(lbl, pre, post)
`endif
`endif

@@ src/nws_pkg.sv @@
// Shared types, constants and fixed-point helpers of the nearest waypoint search.
// No dependencies; imported by the CORDIC, the score pipeline and the top level.
package nws_pkg;

	localparam int COUNT_W = 9;
	localparam int INDEX_W = 8;
	localparam int LAT_W = 31;
	localparam int LON_W = 32;
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_W = 34;
	localparam int PIPE_LAT = 4 + CORDIC_STEPS + 3;
	localparam int CAPTURE_POS = 3 + CORDIC_STEPS;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
	localparam logic [32:0] DEG_TO_RAD_Q = 33'd4797524517;
	localparam logic [30:0] QUARTER_Q24 = 31'd1509949440;
	localparam logic [31:0] HALF_Q24 = 32'd3019898880;
	localparam logic [32:0] FULL_Q24 = 33'd6039797760;
	localparam logic [30:0] ONE_Q30 = 31'h40000000;
	localparam logic [31:0] A_MAX = 32'hFFFFFFFE;
	localparam logic [31:0] SCORE_INIT = 32'hFFFFFFFF;

	localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_RESP
	} nws_state_t;

	typedef struct packed {
		logic               valid;
		logic               self_beat;
		logic               skip;
		logic               last;
		logic [INDEX_W-1:0] idx;
	} beat_tag_t;

	function automatic logic [31:0] mod_half(input logic [32:0] m);
		logic [32:0] r;
		if (m >= FULL_Q24) begin
			r = m - FULL_Q24;
		end else if (m >= 33'(HALF_Q24)) begin
			r = m - 33'(HALF_Q24);
		end else begin
			r = m;
		end
		return r[31:0];
	endfunction

	function automatic logic [30:0] fold_quarter(input logic [31:0] r);
		logic [31:0] f;
		if (r > 32'(QUARTER_Q24)) begin
			f = HALF_Q24 - r;
		end else begin
			f = r;
		end
		return f[30:0];
	endfunction

	function automatic logic [30:0] clamp_unit(input logic signed [CORDIC_W-1:0] v);
		logic [30:0] r;
		if (v[CORDIC_W-1]) begin
			r = '0;
		end else if (v > $signed(CORDIC_W'(ONE_Q30))) begin
			r = ONE_Q30;
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] sin_sq(input logic [30:0] s);
		logic [61:0] p;
		p = 62'(s) * 62'(s);
		return (p[61:60] != 2'b00) ? 32'hFFFFFFFF : p[59:28];
	endfunction

endpackage

@@ src/nws_cordic.sv @@
// Pipelined CORDIC in rotation mode, one register stage per iteration.
// Depends on nws_pkg; gives clamped sine and cosine in Q1.30 from an angle in radians.
module nws_cordic (
	input  logic        clk,
	input  logic [30:0] angle,
	output logic [30:0] sin_out,
	output logic [30:0] cos_out
);
	import nws_pkg::*;

	logic signed [CORDIC_W-1:0] x_q [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_q [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] z_q [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CORDIC_W-1:0] x_in, y_in, z_in, xs, ys, at;
		if (i == 0) begin : g_first
			assign x_in = CORDIC_GAIN;
			assign y_in = '0;
			assign z_in = $signed({3'b000, angle});
		end else begin : g_next
			assign x_in = x_q[i-1];
			assign y_in = y_q[i-1];
			assign z_in = z_q[i-1];
		end
		assign xs = x_in >>> i;
		assign ys = y_in >>> i;
		assign at = $signed(CORDIC_W'(ATAN_Q30[i]));
		always_ff @(posedge clk) begin
			if (!z_in[CORDIC_W-1]) begin
				x_q[i] <= x_in - ys;
				y_q[i] <= y_in + xs;
				z_q[i] <= z_in - at;
			end else begin
				x_q[i] <= x_in + ys;
				y_q[i] <= y_in - xs;
				z_q[i] <= z_in + at;
			end
		end
	end

	assign sin_out = clamp_unit(y_q[CORDIC_STEPS-1]);
	assign cos_out = clamp_unit(x_q[CORDIC_STEPS-1]);

endmodule

@@ src/nws_score_pipe.sv @@
// Haversine score pipeline: angle reduction, three CORDICs and the products.
// Depends on nws_pkg and nws_cordic; takes one table entry per cycle.
module nws_score_pipe (
	input  logic                    clk,
	input  logic                    arst_n,
	input  nws_pkg::beat_tag_t      tag_in,
	input  logic signed [30:0]      lat_in,
	input  logic signed [31:0]      lon_in,
	output nws_pkg::beat_tag_t      tag_out,
	output logic [31:0]             score_out
);
	import nws_pkg::*;

	beat_tag_t tag_q [PIPE_LAT];

	logic signed [30:0] lat1_q;
	logic signed [31:0] lon1_q;
	logic signed [32:0] dlat_c, dlon_c;
	logic [32:0] mlat_s1, mlon_s1;
	logic [31:0] mcos_s1;
	logic [31:0] rlat_s2, rlon_s2, rcos_s2;
	logic [30:0] flat_s3, flon_s3, fcos_s3;
	logic [63:0] plat_c, plon_c, pcos_c;
	logic [30:0] zlat_s4, zlon_s4, zcos_s4;
	logic [30:0] slat, slon, clat, unused_c0, unused_c1, unused_s2;
	logic [30:0] c1_q;
	logic [61:0] pcc_c;
	logic [31:0] sl_s6, so_s6;
	logic [30:0] cc_s6;
	logic [62:0] pt_c;
	logic [31:0] sl_s7;
	logic [32:0] t_s7;
	logic [33:0] sum_c;
	logic [31:0] a_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_LAT; k++) begin
				tag_q[k] <= '0;
			end
		end else begin
			tag_q[0] <= tag_in;
			for (int k = 1; k < PIPE_LAT; k++) begin
				tag_q[k] <= tag_q[k-1];
			end
		end
	end

	assign dlat_c = 33'($signed(lat_in)) - 33'($signed(lat1_q));
	assign dlon_c = 33'($signed(lon_in)) - 33'($signed(lon1_q));

	always_ff @(posedge clk) begin
		if (tag_in.valid && tag_in.self_beat) begin
			lat1_q <= lat_in;
			lon1_q <= lon_in;
		end
		mlat_s1 <= dlat_c[32] ? 33'(-dlat_c) : 33'(dlat_c);
		mlon_s1 <= dlon_c[32] ? 33'(-dlon_c) : 33'(dlon_c);
		mcos_s1 <= lat_in[30] ? {32'(-$signed(lat_in))} << 1 : {32'(lat_in)} << 1;
	end

	always_ff @(posedge clk) begin
		rlat_s2 <= mod_half(mlat_s1);
		rlon_s2 <= mod_half(mlon_s1);
		rcos_s2 <= (mcos_s1 > HALF_Q24) ? 32'(FULL_Q24 - 33'(mcos_s1)) : mcos_s1;
		flat_s3 <= fold_quarter(rlat_s2);
		flon_s3 <= fold_quarter(rlon_s2);
		fcos_s3 <= fold_quarter(rcos_s2);
	end

	assign plat_c = 64'(flat_s3) * 64'(DEG_TO_RAD_Q);
	assign plon_c = 64'(flon_s3) * 64'(DEG_TO_RAD_Q);
	assign pcos_c = 64'(fcos_s3) * 64'(DEG_TO_RAD_Q);

	always_ff @(posedge clk) begin
		zlat_s4 <= plat_c[62:32];
		zlon_s4 <= plon_c[62:32];
		zcos_s4 <= pcos_c[62:32];
	end

	nws_cordic u_cordic_lat (.clk(clk), .angle(zlat_s4), .sin_out(slat), .cos_out(unused_c0));
	nws_cordic u_cordic_lon (.clk(clk), .angle(zlon_s4), .sin_out(slon), .cos_out(unused_c1));
	nws_cordic u_cordic_cos (.clk(clk), .angle(zcos_s4), .sin_out(unused_s2), .cos_out(clat));

	assign pcc_c = 62'(c1_q) * 62'(clat);

	always_ff @(posedge clk) begin
		if (tag_q[CAPTURE_POS].valid && tag_q[CAPTURE_POS].self_beat) begin
			c1_q <= clat;
		end
		sl_s6 <= sin_sq(slat);
		so_s6 <= sin_sq(slon);
		cc_s6 <= pcc_c[60:30];
	end

	assign pt_c = 63'(cc_s6) * 63'(so_s6);
	assign sum_c = 34'(sl_s7) + 34'(t_s7);

	always_ff @(posedge clk) begin
		sl_s7 <= sl_s6;
		t_s7 <= pt_c[62:30];
		a_s8 <= (sum_c > 34'(A_MAX)) ? A_MAX : sum_c[31:0];
	end

	assign tag_out = tag_q[PIPE_LAT-1];
	assign score_out = a_s8;

endmodule

@@ src/nearest_waypoint_search_top.sv @@
// A write beat stores one waypoint in the table; the table has one write port and
// one read port. A query beat reads its own entry, then streams the first
// min(waypoint_count, TABLE_DEPTH) entries from the table's read port at one per cycle through
// a 31-stage haversine score pipeline. Once the last entry leaves the pipeline the result is
// presented, and the next beat is taken in the cycle after it is loaded, or later while an
// earlier result still waits on the output. A query whose index is not below the count
// goes straight to the response state without a walk and presents an error status.
// A new beat is taken while the previous result still waits on the output.
// Depends on nws_pkg, nws_score_pipe and nearest_waypoint_search_top_defines.svh.
`include "nearest_waypoint_search_top_defines.svh"
module nearest_waypoint_search_top #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  entry_index,
	input  logic signed [30:0] latitude,
	input  logic signed [31:0] longitude,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  nearest_index,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);
	import nws_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DEPTH_CAP = (TABLE_DEPTH < 512) ? TABLE_DEPTH : 511;

	logic [62:0] wp_mem [TABLE_DEPTH];
	logic [62:0] rd_data_q;
	beat_tag_t rd_tag_q, rd_tag_d, ptag;
	logic [31:0] pscore;

	nws_state_t state_q, state_d;
	logic [COUNT_W-1:0] count_q, limit_q, issue_q, limit_c;
	logic [INDEX_W-1:0] qidx_q, best_idx_q, nearest_index_q;
	logic [31:0] best_q;
	logic err_q, out_valid_q, status_q;
	logic in_range, accept_query, wr_en, out_load, issue_last;
	logic [AW-1:0] rd_addr;

	assign cfg_ready = 1'b1;
	assign limit_c = (32'(count_q) > DEPTH_CAP) ? COUNT_W'(DEPTH_CAP) : count_q;
	assign in_range = {1'b0, entry_index} < limit_c;
	assign accept_query = (state_q == ST_IDLE) && in_valid && (opcode == OP_QUERY);
	assign issue_last = issue_q == (limit_q - 1'b1);

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		rd_tag_d = '0;
		rd_addr = AW'(issue_q);
		wr_en = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == OP_WRITE) begin
						wr_en = 32'(entry_index) < TABLE_DEPTH;
					end else if (in_range) begin
						rd_addr = AW'(entry_index);
						rd_tag_d.valid = 1'b1;
						rd_tag_d.self_beat = 1'b1;
						state_d = ST_WALK;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_WALK: begin
				rd_tag_d.valid = 1'b1;
				rd_tag_d.skip = issue_q == {1'b0, qidx_q};
				rd_tag_d.last = issue_last;
				rd_tag_d.idx = issue_q[INDEX_W-1:0];
				if (issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (ptag.valid && ptag.last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wp_mem[AW'(entry_index)] <= {latitude, longitude};
		end
		rd_data_q <= wp_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_tag_q <= '0;
			count_q <= '0;
			issue_q <= '0;
			limit_q <= '0;
			qidx_q <= '0;
			err_q <= 1'b0;
			best_q <= SCORE_INIT;
			best_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_tag_q <= rd_tag_d;
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			if (accept_query) begin
				issue_q <= '0;
				limit_q <= limit_c;
				qidx_q <= entry_index;
				err_q <= !in_range;
				best_q <= SCORE_INIT;
				best_idx_q <= '0;
			end else begin
				if (state_q == ST_WALK) begin
					issue_q <= issue_q + 1'b1;
				end
				if (ptag.valid && !ptag.self_beat && !ptag.skip && (pscore < best_q)) begin
					best_q <= pscore;
					best_idx_q <= ptag.idx;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			nearest_index_q <= err_q ? '0 : best_idx_q;
			status_q <= err_q ? STATUS_RANGE : STATUS_OK;
		end
	end

	nws_score_pipe u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (rd_tag_q),
		.lat_in   ($signed(rd_data_q[62:32])),
		.lon_in   ($signed(rd_data_q[31:0])),
		.tag_out  (ptag),
		.score_out(pscore)
	);

	assign out_valid = out_valid_q;
	assign nearest_index = nearest_index_q;
	assign status = status_q;

	`NWS_ASSERT_IMP(a_walk_bound, state_q == ST_WALK, issue_q < limit_q)
	`NWS_ASSERT_IMP(a_self_first, rd_tag_q.valid && rd_tag_q.self_beat, state_q == ST_WALK)
	`NWS_ASSERT_IMP(a_last_drain, ptag.valid && ptag.last, state_q == ST_DRAIN)
	`NWS_ASSERT_IMP(a_score_cap, ptag.valid && !ptag.self_beat, pscore != SCORE_INIT)

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for nearest_waypoint_search_top: writes waypoints, queries
// the nearest one and compares each answer with a haversine predictor kept here.
// Depends on nws_pkg and the RTL of the block.
module testbench;
	import nws_pkg::*;

	localparam int DEPTH = 256;

	typedef struct {
		logic [7:0] idx;
		logic       st;
	} answer_t;

	class nearest_scoreboard;
		logic signed [31:0] lat_tab [DEPTH];
		logic signed [31:0] lon_tab [DEPTH];
		int unsigned        walk_count;
		answer_t            pending [$];
		int                 mismatches;
		int                 checked;
		int                 errors_seen;

		function new();
			walk_count = 0;
			mismatches = 0;
			checked = 0;
			errors_seen = 0;
		endfunction

		function automatic longint floor_shift(longint v, int s);
			return v < 0 ? ~((~v) >>> s) : (v >>> s);
		endfunction

		function automatic longint unit_clamp(longint v);
			if (v < 0) return 0;
			if (v > (64'sd1 << 30)) return 64'sd1 << 30;
			return v;
		endfunction

		function automatic void rotate(longint unsigned ang, output longint s,
			output longint c);
			longint z, x, y, xs, ys;
			z = longint'((ang * 64'd4797524517) >> 32);
			x = 64'sh26DD3B6A;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = floor_shift(x, i);
				ys = floor_shift(y, i);
				if (z >= 0) begin
					x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
				end else begin
					x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
				end
			end
			s = unit_clamp(y);
			c = unit_clamp(x);
		endfunction

		function automatic longint unsigned mag(longint v);
			return v < 0 ? longint'(-v) : v;
		endfunction

		function automatic longint unsigned half_angle_sq(longint d);
			longint unsigned r, q;
			longint s, c;
			r = mag(d) % (64'd180 << 24);
			if (r > (64'd90 << 24)) r = (64'd180 << 24) - r;
			rotate(r, s, c);
			q = (s * s) >> 28;
			return q > 64'hFFFFFFFF ? 64'hFFFFFFFF : q;
		endfunction

		function automatic longint unsigned lat_cosine(longint lat);
			longint unsigned r;
			longint s, c;
			r = (mag(lat) * 2) % (64'd360 << 24);
			if (r > (64'd180 << 24)) r = (64'd360 << 24) - r;
			if (r > (64'd90 << 24)) r = (64'd180 << 24) - r;
			rotate(r, s, c);
			return c;
		endfunction

		function automatic longint unsigned haversine(int i, int j);
			longint unsigned sl, so, cc, a;
			sl = half_angle_sq(longint'(lat_tab[i]) - longint'(lat_tab[j]));
			so = half_angle_sq(longint'(lon_tab[i]) - longint'(lon_tab[j]));
			cc = (lat_cosine(lat_tab[i]) * lat_cosine(lat_tab[j])) >> 30;
			a = sl + ((cc * so) >> 30);
			return a > 64'hFFFFFFFE ? 64'hFFFFFFFE : a;
		endfunction

		function void note_beat(logic op, logic [7:0] idx, logic signed [30:0] lat,
			logic signed [31:0] lon);
			answer_t ans;
			int unsigned lim;
			longint unsigned best, a;
			if (op == OP_WRITE) begin
				lat_tab[idx] = 32'(lat);
				lon_tab[idx] = lon;
				return;
			end
			lim = walk_count < DEPTH ? walk_count : DEPTH;
			if (idx >= lim) begin
				ans.idx = 0;
				ans.st = STATUS_RANGE;
			end else begin
				best = 64'hFFFFFFFF;
				ans.idx = 0;
				ans.st = STATUS_OK;
				for (int i = 0; i < lim; i++) begin
					if (i == idx) continue;
					a = haversine(idx, i);
					if (a < best) begin
						best = a;
						ans.idx = i[7:0];
					end
				end
			end
			pending.insert(pending.size(), ans);
		endfunction

		function void check_answer(logic [7:0] idx, logic st);
			answer_t e;
			checked++;
			if (st == STATUS_RANGE) errors_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result index=%0d status=%0d", idx, st);
				return;
			end
			e = pending.pop_front();
			if (e.idx !== idx || e.st !== st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected index=%0d status=%0d, got index=%0d status=%0d",
						e.idx, e.st, idx, st);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              opcode;
	logic [7:0]        entry_index;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        nearest_index;
	logic              status;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [8:0]        cfg_data;

	nearest_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	int queries_sent;
	int writes_sent;

	nearest_waypoint_search_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.entry_index(entry_index), .latitude(latitude), .longitude(longitude),
		.out_valid(out_valid), .out_ready(out_ready),
		.nearest_index(nearest_index), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("timeout");
		$display("testbench NOT OK");
		$finish;
	end

	// Receiver: random stalls, results are checked at the accepting edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_answer(nearest_index, status);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Valid stays high after a beat is accepted; the next beat, an idle cycle or a drain
	// lowers it or replaces the payload at that same edge.
	task automatic send_beat(logic op, logic [7:0] idx, logic signed [30:0] lat,
		logic signed [31:0] lon);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		entry_index <= idx;
		latitude <= lat;
		longitude <= lon;
		do @(posedge clk); while (!in_ready);
		board.note_beat(op, idx, lat, lon);
		if (op == OP_WRITE) begin
			writes_sent++;
		end else begin
			queries_sent++;
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_count(logic [8:0] n);
		drain();
		cfg_valid <= 1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		board.walk_count = n;
		cfg_valid <= 0;
	endtask

	function automatic logic signed [30:0] rand_lat();
		case ($urandom_range(5))
			0: return 31'sd754974720;
			1: return -31'sd754974720;
			2: return 31'($urandom());
			default: return 31'($signed($urandom_range(1509949440)) - 754974720);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_lon();
		case ($urandom_range(5))
			0: return 32'sd1509949440;
			1: return -32'sd1509949440;
			2: return 32'($urandom());
			default: return 32'($signed($urandom() % 32'd3019898881) - 1509949440);
		endcase
	endfunction

	// Queries only name written entries below the count, or out-of-range indexes.
	task automatic random_beat(int cnt);
		logic [7:0] idx;
		int lim;
		lim = cnt < DEPTH ? cnt : DEPTH;
		if ($urandom_range(99) < 40) begin
			idx = (lim > 0 && $urandom_range(3) != 0) ? 8'($urandom_range(lim - 1))
				: 8'($urandom());
			send_beat(OP_WRITE, idx, rand_lat(), rand_lon());
		end else if (lim < DEPTH && $urandom_range(9) == 0) begin
			send_beat(OP_QUERY, 8'($urandom_range(255, lim)), rand_lat(), rand_lon());
		end else if (lim > 0) begin
			send_beat(OP_QUERY, 8'($urandom_range(lim - 1)), 31'($urandom()), 32'($urandom()));
		end else begin
			in_valid <= 0;
			@(posedge clk);
		end
	endtask

	task automatic fill_table(int n);
		for (int i = 0; i < n; i++) send_beat(OP_WRITE, 8'(i), rand_lat(), rand_lon());
	endtask

	initial begin
		int counts [6];
		int cnt;
		board = new();
		queries_sent = 0;
		writes_sent = 0;
		arst_n = 0;
		in_valid = 0;
		opcode = OP_WRITE;
		entry_index = 0;
		latitude = 0;
		longitude = 0;
		cfg_valid = 0;
		cfg_data = 0;
		out_ready = 0;
		send_idle_pct = 12;
		recv_idle_pct = 51;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: count of zero, extremes, poles, ties, lone entry, full table.
		send_beat(OP_QUERY, 0, 0, 0);
		send_beat(OP_WRITE, 0, 31'sd754974720, 32'sd1509949440);
		send_beat(OP_WRITE, 1, -31'sd754974720, -32'sd1509949440);
		send_beat(OP_WRITE, 2, 31'h3FFFFFFF, 32'h7FFFFFFF);
		send_beat(OP_WRITE, 3, 31'sh40000000, 32'sh80000000);
		send_beat(OP_WRITE, 4, 0, 0);
		send_beat(OP_WRITE, 5, 0, 0);
		set_count(1);
		send_beat(OP_QUERY, 0, 0, 0);
		send_beat(OP_QUERY, 1, 0, 0);
		set_count(6);
		for (int i = 0; i < 6; i++) send_beat(OP_QUERY, 8'(i), 0, 0);
		send_beat(OP_QUERY, 8'd255, 0, 0);
		fill_table(DEPTH);
		set_count(9'd256);
		send_beat(OP_QUERY, 8'd255, 0, 0);
		send_beat(OP_QUERY, 8'd0, 0, 0);
		set_count(9'd511);
		send_beat(OP_QUERY, 8'd128, 0, 0);

		// Random phases over several counts and idling mixes.
		counts = '{2, 7, 16, 300, 40, 3};
		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				send_idle_pct = 51;
				recv_idle_pct = 12;
			end
			if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			cnt = counts[p];
			set_count(9'(cnt));
			for (int k = 0; k < (cnt > 100 ? 60 : 310); k++) begin
				if (k == 30) drain();
				random_beat(cnt);
			end
		end
		drain();
		$display("Covered %0d writes and %0d queries, %0d results checked, %0d range errors.",
			writes_sent, queries_sent, board.checked, board.errors_seen);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
